/* rtl/core/pst_pkg.sv */
// pst_pkg: shared types and constants for the peer session table
// no dependencies; imported by peer_session_table
`default_nettype none

package pst_pkg;

   // command codes of a request transfer
   localparam logic [1:0] CMD_UPSERT = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_SWEEP  = 2'd2;

   // idle timeout after reset, in seconds
   localparam logic [15:0] TIMEOUT_RESET = 16'd60;

   // one stored session, as kept in the entry memory
   typedef struct packed {
      logic [31:0] tunnel_ip;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [31:0] seen_at;
   } pst_entry_type;

   localparam int ENTRY_BITS = $bits(pst_entry_type);

endpackage

`default_nettype wire

/* rtl/core/pst_ram.sv */
// pst_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies; used for the session entry store
`default_nettype none

module pst_ram #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0]                  wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [DATA_WIDTH-1:0]                  rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/peer_session_table.sv */
// peer_session_table: session table with lru eviction and idle sweep
// depends on pst_pkg and pst_ram
`default_nettype none

// The block keeps TABLE_ENTRIES peer sessions. Every command (upsert, lookup,
// sweep) walks the whole table once through the single read port of the
// entry memory, one entry per cycle, and then writes back and presents the
// response once the output register is free; a skipped sweep or an unused
// command goes straight to that last step. The memory read port and the one
// magnitude comparator that serves both the oldest-entry search and the idle
// check bound the walk. req_stall stays high from a request transfer until
// its response is loaded into the output register; the response then waits
// there while the next request is taken. Entry valid bits live in flip-flops
// that reset clears, so no memory clearing pass is needed. The idle timeout
// register may only be written while the block has no work in flight.
module peer_session_table
   import pst_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [31:0] req_tunnel_ip,
   input  wire logic [31:0] req_peer_ip,
   input  wire logic [15:0] req_peer_port,
   input  wire logic        req_peer_given,
   input  wire logic [31:0] req_now_seconds,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_slot,
   output logic             rsp_matched,
   output logic             rsp_evicted,
   output logic [31:0]      rsp_found_peer_ip,
   output logic [15:0]      rsp_found_peer_port,
   output logic [4:0]       rsp_expired_count,
   output logic             rsp_sweep_skipped
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   // control state
   logic [1:0]               state_ff, state_in;
   logic [CNT_W-1:0]         rd_cnt_ff, rd_cnt_in;      // next entry to read
   logic                     chk_valid_ff, chk_valid_in; // read data is live
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0]              last_sweep_ff, last_sweep_in;
   logic [15:0]              timeout_ff, timeout_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // latched request
   logic [1:0]  cmd_ff, cmd_in;
   logic [31:0] tip_ff, tip_in;
   logic [31:0] pip_ff, pip_in;
   logic [15:0] pport_ff, pport_in;
   logic        given_ff, given_in;
   logic [31:0] now_ff, now_in;

   // scan trackers
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic             peer_found_ff, peer_found_in;
   logic [IDX_W-1:0] peer_idx_ff, peer_idx_in;
   logic             tun_found_ff, tun_found_in;
   logic [IDX_W-1:0] tun_idx_ff, tun_idx_in;
   logic [31:0]      tun_pip_ff, tun_pip_in;
   logic [15:0]      tun_pport_ff, tun_pport_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             have_old_ff, have_old_in;
   logic [IDX_W-1:0] old_idx_ff, old_idx_in;
   logic [31:0]      old_seen_ff, old_seen_in;
   logic [CNT_W-1:0] exp_cnt_ff, exp_cnt_in;
   logic             skip_ff, skip_in;

   // response payload
   logic [3:0]  rsp_slot_ff, rsp_slot_in;
   logic        rsp_matched_ff, rsp_matched_in;
   logic        rsp_evicted_ff, rsp_evicted_in;
   logic [31:0] rsp_pip_ff, rsp_pip_in;
   logic [15:0] rsp_pport_ff, rsp_pport_in;
   logic [4:0]  rsp_exp_ff, rsp_exp_in;
   logic        rsp_skip_ff, rsp_skip_in;

   // entry memory
   logic                    ram_wr_en;
   logic [IDX_W-1:0]        ram_wr_addr;
   logic [ENTRY_BITS-1:0]   ram_wr_data;
   logic                    ram_rd_en;
   logic [IDX_W-1:0]        ram_rd_addr;
   logic [ENTRY_BITS-1:0]   ram_rd_data;

   pst_ram #(
      .DATA_WIDTH (ENTRY_BITS),
      .DEPTH      (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // entry under check, from last cycle's read
   pst_entry_type ent;
   logic          ent_v;
   logic [32:0]   idle_diff;   // now minus the entry stamp, borrow as sign
   logic [31:0]   cmp_a;
   logic [31:0]   cmp_b;
   logic          cmp_gt;      // the shared magnitude comparator

   assign ent       = pst_entry_type'(ram_rd_data);
   assign ent_v     = valid_ff[chk_idx_ff];
   assign idle_diff = {1'b0, now_ff} - {1'b0, ent.seen_at};

   // sweep asks idle > timeout, upsert asks whether the oldest stamp so far
   // is above this entry's stamp
   always_comb begin
      if (cmd_ff == CMD_SWEEP) begin
         cmp_a = idle_diff[31:0];
         cmp_b = {16'd0, timeout_ff};
      end else begin
         cmp_a = old_seen_ff;
         cmp_b = ent.seen_at;
      end
   end
   assign cmp_gt = cmp_a > cmp_b;

   // write-back decision, valid in ST_WRITE
   logic [IDX_W-1:0] res_idx;
   logic             res_matched;
   logic             res_evicted;
   logic [31:0]      res_pip;
   logic [15:0]      res_pport;
   logic             res_write;
   logic             out_free;

   always_comb begin
      res_idx     = '0;
      res_matched = 1'b0;
      res_evicted = 1'b0;
      res_pip     = '0;
      res_pport   = '0;
      res_write   = 1'b0;
      case (cmd_ff)
         CMD_UPSERT: begin
            res_write = 1'b1;
            if (peer_found_ff) begin
               res_idx     = peer_idx_ff;
               res_matched = 1'b1;
            end else if (tun_found_ff) begin
               res_idx     = tun_idx_ff;
               res_matched = 1'b1;
            end else if (free_found_ff) begin
               res_idx = free_idx_ff;
            end else begin
               res_idx     = old_idx_ff;
               res_evicted = 1'b1;
            end
            // peer match only happens with a given peer, so without one a
            // match came from the tunnel ip and keeps its stored peer
            if (given_ff) begin
               res_pip   = pip_ff;
               res_pport = pport_ff;
            end else if (tun_found_ff) begin
               res_pip   = tun_pip_ff;
               res_pport = tun_pport_ff;
            end
         end
         CMD_LOOKUP: begin
            if (tun_found_ff) begin
               res_write   = 1'b1;
               res_idx     = tun_idx_ff;
               res_matched = 1'b1;
               res_pip     = tun_pip_ff;
               res_pport   = tun_pport_ff;
            end
         end
         default: begin
            res_write = 1'b0;
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      rd_cnt_in     = rd_cnt_ff;
      chk_valid_in  = chk_valid_ff;
      valid_in      = valid_ff;
      last_sweep_in = last_sweep_ff;
      timeout_in    = csr_wr_en ? csr_wr_data : timeout_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      cmd_in   = cmd_ff;
      tip_in   = tip_ff;
      pip_in   = pip_ff;
      pport_in = pport_ff;
      given_in = given_ff;
      now_in   = now_ff;

      chk_idx_in    = chk_idx_ff;
      peer_found_in = peer_found_ff;
      peer_idx_in   = peer_idx_ff;
      tun_found_in  = tun_found_ff;
      tun_idx_in    = tun_idx_ff;
      tun_pip_in    = tun_pip_ff;
      tun_pport_in  = tun_pport_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      have_old_in   = have_old_ff;
      old_idx_in    = old_idx_ff;
      old_seen_in   = old_seen_ff;
      exp_cnt_in    = exp_cnt_ff;
      skip_in       = skip_ff;

      rsp_slot_in    = rsp_slot_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_pip_in     = rsp_pip_ff;
      rsp_pport_in   = rsp_pport_ff;
      rsp_exp_in     = rsp_exp_ff;
      rsp_skip_in    = rsp_skip_ff;

      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_cnt_ff[IDX_W-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = res_idx;
      ram_wr_data = {tip_ff, res_pip, res_pport, now_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // request transfer: latch it and arm the trackers
               cmd_in        = req_command;
               tip_in        = req_tunnel_ip;
               pip_in        = req_peer_ip;
               pport_in      = req_peer_port;
               given_in      = req_peer_given;
               now_in        = req_now_seconds;
               rd_cnt_in     = '0;
               chk_valid_in  = 1'b0;
               peer_found_in = 1'b0;
               tun_found_in  = 1'b0;
               free_found_in = 1'b0;
               have_old_in   = 1'b0;
               exp_cnt_in    = '0;
               skip_in       = 1'b0;
               if (req_command == CMD_SWEEP && req_now_seconds == last_sweep_ff) begin
                  // sweep already done for this second
                  skip_in  = 1'b1;
                  state_in = ST_WRITE;
               end else if (req_command == CMD_SWEEP) begin
                  last_sweep_in = req_now_seconds;
                  state_in      = ST_SCAN;
               end else if (req_command == CMD_UPSERT || req_command == CMD_LOOKUP) begin
                  state_in = ST_SCAN;
               end else begin
                  // unused command: all-zero response
                  state_in = ST_WRITE;
               end
            end
         end

         ST_SCAN: begin
            // read side: one entry per cycle
            if (rd_cnt_ff != CNT_LAST) begin
               ram_rd_en    = 1'b1;
               rd_cnt_in    = rd_cnt_ff + 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in   = rd_cnt_ff[IDX_W-1:0];
            end else begin
               chk_valid_in = 1'b0;
               state_in     = ST_WRITE;
            end

            // check side: entry read last cycle
            if (chk_valid_ff) begin
               case (cmd_ff)
                  CMD_UPSERT: begin
                     if (ent_v && given_ff && !peer_found_ff &&
                         ent.peer_ip == pip_ff && ent.peer_port == pport_ff) begin
                        peer_found_in = 1'b1;
                        peer_idx_in   = chk_idx_ff;
                     end
                     if (ent_v && !tun_found_ff && ent.tunnel_ip == tip_ff) begin
                        tun_found_in = 1'b1;
                        tun_idx_in   = chk_idx_ff;
                        tun_pip_in   = ent.peer_ip;
                        tun_pport_in = ent.peer_port;
                     end
                     if (!ent_v && !free_found_ff) begin
                        free_found_in = 1'b1;
                        free_idx_in   = chk_idx_ff;
                     end
                     // strictly older wins, so the first of equals stays
                     if (ent_v && (!have_old_ff || cmp_gt)) begin
                        have_old_in = 1'b1;
                        old_idx_in  = chk_idx_ff;
                        old_seen_in = ent.seen_at;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (ent_v && !tun_found_ff && ent.tunnel_ip == tip_ff) begin
                        tun_found_in = 1'b1;
                        tun_idx_in   = chk_idx_ff;
                        tun_pip_in   = ent.peer_ip;
                        tun_pport_in = ent.peer_port;
                     end
                  end
                  CMD_SWEEP: begin
                     // a stamp in the future never expires
                     if (ent_v && !idle_diff[32] && cmp_gt) begin
                        valid_in[chk_idx_ff] = 1'b0;
                        exp_cnt_in           = exp_cnt_ff + 1'b1;
                     end
                  end
                  default: begin
                     exp_cnt_in = exp_cnt_ff;
                  end
               endcase
            end
         end

         ST_WRITE: begin
            // write back and load the response once the output is free
            if (out_free) begin
               if (res_write) begin
                  ram_wr_en         = 1'b1;
                  valid_in[res_idx] = 1'b1;
               end
               rsp_valid_in   = 1'b1;
               rsp_slot_in    = 4'(res_idx);
               rsp_matched_in = res_matched;
               rsp_evicted_in = res_evicted;
               rsp_pip_in     = res_pip;
               rsp_pport_in   = res_pport;
               rsp_exp_in     = 5'(exp_cnt_ff);
               rsp_skip_in    = skip_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_cnt_ff     <= '0;
         chk_valid_ff  <= 1'b0;
         valid_ff      <= '0;
         last_sweep_ff <= '0;
         timeout_ff    <= TIMEOUT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_cnt_ff     <= rd_cnt_in;
         chk_valid_ff  <= chk_valid_in;
         valid_ff      <= valid_in;
         last_sweep_ff <= last_sweep_in;
         timeout_ff    <= timeout_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      tip_ff         <= tip_in;
      pip_ff         <= pip_in;
      pport_ff       <= pport_in;
      given_ff       <= given_in;
      now_ff         <= now_in;
      chk_idx_ff     <= chk_idx_in;
      peer_found_ff  <= peer_found_in;
      peer_idx_ff    <= peer_idx_in;
      tun_found_ff   <= tun_found_in;
      tun_idx_ff     <= tun_idx_in;
      tun_pip_ff     <= tun_pip_in;
      tun_pport_ff   <= tun_pport_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      have_old_ff    <= have_old_in;
      old_idx_ff     <= old_idx_in;
      old_seen_ff    <= old_seen_in;
      exp_cnt_ff     <= exp_cnt_in;
      skip_ff        <= skip_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_pip_ff     <= rsp_pip_in;
      rsp_pport_ff   <= rsp_pport_in;
      rsp_exp_ff     <= rsp_exp_in;
      rsp_skip_ff    <= rsp_skip_in;
   end

   // ports
   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_slot            = rsp_slot_ff;
   assign rsp_matched         = rsp_matched_ff;
   assign rsp_evicted         = rsp_evicted_ff;
   assign rsp_found_peer_ip   = rsp_pip_ff;
   assign rsp_found_peer_port = rsp_pport_ff;
   assign rsp_expired_count   = rsp_exp_ff;
   assign rsp_sweep_skipped   = rsp_skip_ff;

endmodule

`default_nettype wire

/* rtl/core/pst_checker.sv */
// pst_checker: port-level assertions for the peer session table
// no dependencies; bound to peer_session_table below
`default_nettype none

module pst_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [3:0]  rsp_slot,
   input wire logic        rsp_matched,
   input wire logic        rsp_evicted,
   input wire logic [31:0] rsp_found_peer_ip,
   input wire logic [15:0] rsp_found_peer_port,
   input wire logic [4:0]  rsp_expired_count,
   input wire logic        rsp_sweep_skipped
);

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one request at a time: a request transfer closes the input
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while another is in work");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_slot) &&
      $stable(rsp_found_peer_ip) && $stable(rsp_expired_count)))
      else $error("stalled response changed");

   // a match and an eviction never come together
   a_match_or_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_matched && rsp_evicted))
      else $error("matched and evicted both set");

   // sweep responses carry no slot or peer
   a_sweep_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_sweep_skipped || rsp_expired_count != 5'd0)) |->
      (rsp_slot == 4'd0 && !rsp_matched && !rsp_evicted &&
       rsp_found_peer_ip == 32'd0 && rsp_found_peer_port == 16'd0 &&
       !(rsp_sweep_skipped && rsp_expired_count != 5'd0)))
      else $error("sweep response carries entry fields");

endmodule

bind peer_session_table pst_checker u_pst_checker (.*);

`default_nettype wire

/* tb/peer_session_table_test.sv */
// peer_session_table_test: self-checking testbench for the peer session table
// predicts every response from its own copy of the table and idle timeout
// depends on pst_pkg and peer_session_table only
`timescale 1ns / 100ps

module peer_session_table_test
   import pst_pkg::*;
;

   localparam int ENTRIES = 16;
   // the one command code the package leaves unnamed; the block must ignore it
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = ENTRIES + 8;
   localparam int PHASE_ITEMS = 283;
   localparam int MAX_PRINTED = 40;

   // one response as the block should present it
   typedef struct packed {
      logic [3:0]  slot;
      logic        matched;
      logic        evicted;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [4:0]  expired_count;
      logic        sweep_skipped;
   } session_result_type;

   // clock, reset and block ports; every input known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_UPSERT;
   logic [31:0] req_tunnel_ip = '0;
   logic [31:0] req_peer_ip = '0;
   logic [15:0] req_peer_port = '0;
   logic        req_peer_given = 1'b0;
   logic [31:0] req_now_seconds = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_slot;
   logic        rsp_matched;
   logic        rsp_evicted;
   logic [31:0] rsp_found_peer_ip;
   logic [15:0] rsp_found_peer_port;
   logic [4:0]  rsp_expired_count;
   logic        rsp_sweep_skipped;

   // predicted table contents and timeout, kept in step with accepted requests
   logic        tbl_valid [ENTRIES];
   logic [31:0] tbl_tunnel_ip [ENTRIES];
   logic [31:0] tbl_peer_ip [ENTRIES];
   logic [15:0] tbl_peer_port [ENTRIES];
   logic [31:0] tbl_seen_at [ENTRIES];
   logic [31:0] model_sweep_time;
   logic [15:0] model_timeout;

   // responses still owed by the block, oldest first
   session_result_type expected_results [$];

   // idling knobs, in percent (gaps per request, stalls per cycle); zero turns a side's idling off
   int gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   int error_count = 0;

   // what the run went through, for the closing summary
   int n_upserts = 0;
   int n_lookups = 0;
   int n_sweeps = 0;
   int n_skipped = 0;
   int n_unused = 0;
   int n_matches = 0;
   int n_evictions = 0;
   int n_expired = 0;
   int n_timeouts = 0;

   // session pools so that random traffic keeps hitting live entries
   logic [31:0] tunnel_pool [24];
   logic [31:0] peer_ip_pool [8];
   logic [15:0] peer_port_pool [8];

   peer_session_table #(
      .TABLE_ENTRIES(ENTRIES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_tunnel_ip(req_tunnel_ip),
      .req_peer_ip(req_peer_ip),
      .req_peer_port(req_peer_port),
      .req_peer_given(req_peer_given),
      .req_now_seconds(req_now_seconds),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_slot(rsp_slot),
      .rsp_matched(rsp_matched),
      .rsp_evicted(rsp_evicted),
      .rsp_found_peer_ip(rsp_found_peer_ip),
      .rsp_found_peer_port(rsp_found_peer_port),
      .rsp_expired_count(rsp_expired_count),
      .rsp_sweep_skipped(rsp_sweep_skipped)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // table predictor
   // ------------------------------------------------------------------

   // first valid entry holding this tunnel address, -1 when none
   function automatic int find_tunnel(input logic [31:0] tunnel_ip);
      int hit;
      hit = -1;
      for (int k = 0; k < ENTRIES && hit < 0; k++)
         if (tbl_valid[k] && tbl_tunnel_ip[k] == tunnel_ip) hit = k;
      return hit;
   endfunction

   // applies one accepted request to the table copy and returns its response
   function automatic session_result_type predict_session(input logic [1:0] command,
         input logic [31:0] tunnel_ip, input logic [31:0] peer_ip,
         input logic [15:0] peer_port, input logic peer_given, input logic [31:0] now_s);
      session_result_type res;
      int hit;
      longint idle;
      res = '0;
      hit = -1;
      case (command)
         CMD_UPSERT: begin
            n_upserts++;
            // a known peer address wins over the tunnel address
            if (peer_given)
               for (int k = 0; k < ENTRIES && hit < 0; k++)
                  if (tbl_valid[k] && tbl_peer_ip[k] == peer_ip &&
                      tbl_peer_port[k] == peer_port) hit = k;
            if (hit < 0) hit = find_tunnel(tunnel_ip);
            if (hit >= 0) begin
               res.matched = 1'b1;
               n_matches++;
            end else begin
               // lowest free slot, else the least recently seen (lowest index on ties)
               for (int k = ENTRIES - 1; k >= 0; k--)
                  if (!tbl_valid[k]) hit = k;
               if (hit < 0) begin
                  hit = 0;
                  for (int k = 1; k < ENTRIES; k++)
                     if (tbl_seen_at[k] < tbl_seen_at[hit]) hit = k;
                  res.evicted = 1'b1;
                  n_evictions++;
               end
               tbl_valid[hit] = 1'b1;
               tbl_peer_ip[hit] = '0;
               tbl_peer_port[hit] = '0;
            end
            tbl_tunnel_ip[hit] = tunnel_ip;
            if (peer_given) begin
               tbl_peer_ip[hit] = peer_ip;
               tbl_peer_port[hit] = peer_port;
            end
            tbl_seen_at[hit] = now_s;
         end
         CMD_LOOKUP: begin
            n_lookups++;
            hit = find_tunnel(tunnel_ip);
            if (hit >= 0) begin
               res.matched = 1'b1;
               tbl_seen_at[hit] = now_s;
               n_matches++;
            end
         end
         CMD_SWEEP: begin
            n_sweeps++;
            if (now_s == model_sweep_time) begin
               res.sweep_skipped = 1'b1;
               n_skipped++;
            end else begin
               model_sweep_time = now_s;
               for (int k = 0; k < ENTRIES; k++) begin
                  // signed idleness: a last-seen ahead of now never expires
                  idle = {32'd0, now_s} - {32'd0, tbl_seen_at[k]};
                  if (tbl_valid[k] && idle > longint'({48'd0, model_timeout})) begin
                     tbl_valid[k] = 1'b0;
                     tbl_tunnel_ip[k] = '0;
                     tbl_peer_ip[k] = '0;
                     tbl_peer_port[k] = '0;
                     tbl_seen_at[k] = '0;
                     res.expired_count++;
                     n_expired++;
                  end
               end
            end
         end
         default: n_unused++;
      endcase
      if (hit >= 0) begin
         res.slot = hit[3:0];
         res.peer_ip = tbl_peer_ip[hit];
         res.peer_port = tbl_peer_port[hit];
      end
      return res;
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // one request transfer; valid is left high so a following call can go back to back
   task automatic send_request(input logic [1:0] command, input logic [31:0] tunnel_ip,
         input logic [31:0] peer_ip, input logic [15:0] peer_port,
         input logic peer_given, input logic [31:0] now_s);
      int gap;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= command;
      req_tunnel_ip <= tunnel_ip;
      req_peer_ip <= peer_ip;
      req_peer_port <= peer_port;
      req_peer_given <= peer_given;
      req_now_seconds <= now_s;
      // payload holds steady until the transfer happens
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_results.push_back(predict_session(command, tunnel_ip, peer_ip, peer_port,
                                                 peer_given, now_s));
   endtask

   // sender holds off until every owed response has been taken, then lets the block settle
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // timeout register is only touched with nothing in flight
   task automatic write_idle_timeout(input logic [15:0] seconds);
      drain_responses();
      csr_wr_en <= 1'b1;
      csr_wr_data <= seconds;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model_timeout = seconds;
      n_timeouts++;
   endtask

   // ------------------------------------------------------------------
   // response side: random stall bursts, checker and watchdog
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         // starts a stall burst; stall_left holds what is left of it
         stall_left = $urandom_range(0, 11);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
         input logic [31:0] want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
   endtask

   // every response transfer is held against the oldest prediction
   always @(posedge clock) begin
      session_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_results.size() == 0) begin
            report_mismatch("response with none owed, slot", {28'd0, rsp_slot}, '0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_slot !== want.slot)
               report_mismatch("slot", 32'(rsp_slot), 32'(want.slot));
            if (rsp_matched !== want.matched)
               report_mismatch("matched", 32'(rsp_matched), 32'(want.matched));
            if (rsp_evicted !== want.evicted)
               report_mismatch("evicted", 32'(rsp_evicted), 32'(want.evicted));
            if (rsp_found_peer_ip !== want.peer_ip)
               report_mismatch("found_peer_ip", rsp_found_peer_ip, want.peer_ip);
            if (rsp_found_peer_port !== want.peer_port)
               report_mismatch("found_peer_port", 32'(rsp_found_peer_port),
                               32'(want.peer_port));
            if (rsp_expired_count !== want.expired_count)
               report_mismatch("expired_count", 32'(rsp_expired_count),
                               32'(want.expired_count));
            if (rsp_sweep_skipped !== want.sweep_skipped)
               report_mismatch("sweep_skipped", 32'(rsp_sweep_skipped),
                               32'(want.sweep_skipped));
         end
      end
   end

   // stops a hung run: too many cycles without a transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // right after reset the last sweep time is zero, so a sweep at zero is skipped
   task automatic test_reset_sweep();
      send_request(CMD_SWEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'd0);
   endtask

   // command 3 leaves the table alone and answers all zero
   task automatic test_unused_command();
      send_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
   endtask

   // new entries, matching by peer then by tunnel, peerless upserts keep the peer
   task automatic test_upsert_matching();
      // peer fields ignored when not given: entry keeps a zero peer
      send_request(CMD_UPSERT, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 32'd100);
      // peer 0:0 given matches the peerless entry
      send_request(CMD_UPSERT, 32'h0B00_0001, 32'h0000_0000, 16'h0000, 1'b1, 32'd110);
      send_request(CMD_UPSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'd200);
      // same peer, new tunnel address: the peer roamed
      send_request(CMD_UPSERT, 32'h0A00_0002, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'd300);
      // unknown peer, known tunnel: match on tunnel and take the new peer
      send_request(CMD_UPSERT, 32'h0B00_0001, 32'h0102_0304, 16'd5000, 1'b1, 32'd310);
      // no peer given on a matched entry keeps its peer
      send_request(CMD_UPSERT, 32'h0B00_0001, 32'h5555_AAAA, 16'h5A5A, 1'b0, 32'd320);
   endtask

   // hits refresh last-seen, misses change nothing
   task automatic test_lookup();
      send_request(CMD_LOOKUP, 32'h0A00_0002, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'd350);
      send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 16'h0, 1'b0, 32'd360);
      send_request(CMD_LOOKUP, 32'h0000_0000, 32'h0, 16'h0, 1'b0, 32'd370);
      // explicit hold-off with everything drained
      drain_responses();
   endtask

   // sweeps at the timeout extremes, repeated times and last-seen in the future
   task automatic test_idle_expiry();
      send_request(CMD_UPSERT, 32'h0A00_0003, 32'h0A0A_0A0A, 16'd1, 1'b1, 32'hFFFF_FFFF);
      send_request(CMD_SWEEP, 32'h0, 32'h0, 16'h0, 1'b0, 32'd400);
      send_request(CMD_SWEEP, 32'h0, 32'h0, 16'h0, 1'b0, 32'd400);
      write_idle_timeout(16'd0);
      send_request(CMD_SWEEP, 32'h0, 32'h0, 16'h0, 1'b0, 32'd401);
      write_idle_timeout(16'hFFFF);
      send_request(CMD_UPSERT, 32'h0C00_0001, 32'h0C0C_0C0C, 16'd2, 1'b1, 32'd402);
      // idleness exactly at the limit survives, one more second frees it
      send_request(CMD_SWEEP, 32'h0, 32'h0, 16'h0, 1'b0, 32'd402 + 32'd65535);
      send_request(CMD_SWEEP, 32'h0, 32'h0, 16'h0, 1'b0, 32'd402 + 32'd65536);
      write_idle_timeout(TIMEOUT_RESET);
      send_request(CMD_SWEEP, 32'h0, 32'h0, 16'h0, 1'b0, 32'hFFFF_FFFF);
   endtask

   // sessions drawn from small pools so the table fills, evicts and expires
   task automatic test_random_traffic(input int item_count, input logic [31:0] start_time);
      logic [31:0] now_s;
      logic [31:0] tunnel_ip;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [1:0]  command;
      int roll;
      int sent;
      foreach (tunnel_pool[i]) tunnel_pool[i] = $urandom;
      foreach (peer_ip_pool[i]) peer_ip_pool[i] = $urandom;
      foreach (peer_port_pool[i]) peer_port_pool[i] = 16'($urandom);
      now_s = start_time;
      sent = 0;
      while (sent < item_count) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) command = CMD_UPSERT;
         else if (roll < 75) command = CMD_LOOKUP;
         else if (roll < 94) command = CMD_SWEEP;
         else command = CMD_UNUSED;
         // time mostly steps forward, sometimes stands still or jumps anywhere
         roll = $urandom_range(0, 99);
         if (roll < 3) now_s = $urandom;
         else if (roll >= 25) now_s += $urandom_range(1, model_timeout / 8 + 4);
         tunnel_ip = ($urandom_range(0, 19) == 0) ? $urandom : tunnel_pool[$urandom_range(0, 23)];
         if ($urandom_range(0, 9) == 0) begin
            peer_ip = $urandom;
            peer_port = 16'($urandom);
         end else begin
            peer_ip = peer_ip_pool[$urandom_range(0, 7)];
            peer_port = peer_port_pool[$urandom_range(0, 7)];
         end
         send_request(command, tunnel_ip, peer_ip, peer_port, $urandom_range(0, 9) < 7, now_s);
         sent++;
         if ($urandom_range(0, 149) == 0) drain_responses();
      end
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------

   initial begin
      foreach (tbl_valid[k]) begin
         tbl_valid[k] = 1'b0;
         tbl_tunnel_ip[k] = '0;
         tbl_peer_ip[k] = '0;
         tbl_peer_port[k] = '0;
         tbl_seen_at[k] = '0;
      end
      model_sweep_time = '0;
      model_timeout = TIMEOUT_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part with light idling on both sides
      gap_pct = 10;
      stall_pct = 10;
      test_reset_sweep();
      test_unused_command();
      test_upsert_matching();
      test_lookup();
      test_idle_expiry();

      // random phases, each with its own timeout and idling mix
      write_idle_timeout(16'($urandom_range(1, 200)));
      gap_pct = 15;
      stall_pct = 15;
      test_random_traffic(PHASE_ITEMS, 32'd1000);

      // zero timeout and time running across the 32-bit wrap
      write_idle_timeout(16'd0);
      gap_pct = 25;
      stall_pct = 25;
      test_random_traffic(PHASE_ITEMS, 32'hFFFF_FE00);

      write_idle_timeout(16'hFFFF);
      gap_pct = 8;
      stall_pct = 30;
      test_random_traffic(PHASE_ITEMS, $urandom);

      // last stretch runs at full rate with no idling anywhere
      gap_pct = 0;
      stall_pct = 0;
      write_idle_timeout(16'($urandom));
      test_random_traffic(PHASE_ITEMS, $urandom);

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("responses never delivered", expected_results.size(), '0);

      $display("covered %0d upserts, %0d lookups, %0d sweeps (%0d skipped), %0d unused commands",
               n_upserts, n_lookups, n_sweeps, n_skipped, n_unused);
      $display("%0d matches, %0d evictions, %0d entries expired over %0d timeout settings",
               n_matches, n_evictions, n_expired, n_timeouts);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
